[rtl/core/ist_pkg.sv]
// ----------------------------------------------------------------------------
// ist_pkg: shared definitions for the integer set table
// operation codes, default capacity and the control bundle sent to the cells
// ----------------------------------------------------------------------------
package ist_pkg;

  localparam int CAPACITY_DEF = 128;

  localparam int MODE_W  = 2;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 8;

  localparam logic [MODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] OP_QUERY  = 2'd2;

  // broadcast to every cell
  typedef struct packed {
    logic load;    // capture compare against the incoming value
    logic ins_go;  // write key into the cell at the fill position
    logic rem_go;  // cells at or above the hit take their right neighbor
  } ist_ctl_t;

endpackage

[rtl/core/ist_cell.sv]
// ----------------------------------------------------------------------------
// ist_cell: one storage cell of the set chain
// holds one member, compares it with the incoming value, and shifts down
// from its right neighbor on a remove
// ----------------------------------------------------------------------------
module ist_cell
  import ist_pkg::*;
#(
  parameter int IDX     = 0,
  parameter int COUNT_W = 8
) (
  input  logic               clk,
  input  ist_ctl_t           ctl,
  input  logic [COUNT_W-1:0] count,
  input  logic [VALUE_W-1:0] cmp_value,
  input  logic [VALUE_W-1:0] key,
  input  logic [VALUE_W-1:0] right_data,
  input  logic               seen_in,
  output logic [VALUE_W-1:0] data,
  output logic               seen_out
);

  logic [VALUE_W-1:0] data_r, data_nxt;
  logic               match_r, match_nxt;
  logic               occupied;
  logic               at_fill;

  assign occupied = (COUNT_W'(IDX) < count);
  assign at_fill  = (COUNT_W'(IDX) == count);
  assign seen_out = seen_in | match_r;
  assign data     = data_r;

  always_comb begin
    match_nxt = match_r;
    if (ctl.load) begin
      match_nxt = occupied && (data_r == cmp_value);
    end
  end

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins_go && at_fill) begin
      data_nxt = key;
    end else if (ctl.rem_go && seen_out) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= match_nxt;
  end

endmodule

[rtl/core/integer_set_table.sv]
// ----------------------------------------------------------------------------
// integer_set_table: bounded set of distinct 32-bit integers
// a chain of register cells keeps the members packed from cell zero; each
// item inserts, removes or looks up one value and returns one result
// ----------------------------------------------------------------------------
//
//   channel  ports                                       handshake
//   -------  ------------------------------------------  -------------------
//   input    in_mode, in_value                           start && !busy
//   result   out_success, out_count, out_empty_res,      out_valid, 1 cycle
//            out_full_res
//
// for each item, the accept edge registers every cell's compare
// against in_value, the next edge folds the hits along the cell chain and
// applies the insert or the shift-down; the result strobes in the cycle after
// that edge
// busy is high for the one update cycle; no new item is taken while one is being applied
// reset clears the count and the control; cell contents are left as they are
// the receiver cannot stall: out_valid lasts exactly one cycle
//
module integer_set_table
  import ist_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                out_valid,
  output logic                out_success,
  output logic [COUNT_W-1:0]  out_count,
  output logic                out_empty_res,
  output logic                out_full_res
);

  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  logic               state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [MODE_W-1:0]  mode_r;
  logic [VALUE_W-1:0] key_r;

  logic               out_valid_r, out_valid_nxt;
  logic               out_success_r, out_success_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic               out_empty_res_r, out_empty_res_nxt;
  logic               out_full_res_r, out_full_res_nxt;

  logic               accept;
  logic               hit;
  logic               full;
  logic               ins_ok, rem_ok, ok;
  ist_ctl_t           ctl;

  // neighbor links along the chain
  logic [VALUE_W-1:0] data_link [CAPACITY+1];
  logic               seen_link [CAPACITY+1];

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r == ST_UPD);

  // ---- cell chain ----
  assign data_link[CAPACITY] = '0;  // nothing beyond the last cell
  assign seen_link[0]        = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ist_cell #(
      .IDX     (i),
      .COUNT_W (CW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count_r),
      .cmp_value  (in_value),
      .key        (key_r),
      .right_data (data_link[i+1]),
      .seen_in    (seen_link[i]),
      .data       (data_link[i]),
      .seen_out   (seen_link[i+1])
    );
  end

  // hit anywhere in the chain shows at its far end
  assign hit  = seen_link[CAPACITY];
  assign full = (count_r == CW'(CAPACITY));

  // ---- operation decode in the update cycle ----
  always_comb begin
    ins_ok = 1'b0;
    rem_ok = 1'b0;
    ok     = 1'b0;
    unique case (mode_r)
      OP_INSERT: begin
        ins_ok = !hit && !full;  // duplicate or full store is refused
        ok     = ins_ok;
      end
      OP_REMOVE: begin
        rem_ok = hit;
        ok     = hit;
      end
      OP_QUERY: begin
        ok = hit;
      end
      default: begin
        ok = 1'b0;  // meaningless mode leaves the state alone
      end
    endcase
  end

  always_comb begin
    ctl.load   = accept;
    ctl.ins_go = (state_r == ST_UPD) && ins_ok;
    ctl.rem_go = (state_r == ST_UPD) && rem_ok;
  end

  // ---- control and result ----
  always_comb begin
    state_nxt         = state_r;
    count_nxt         = count_r;
    out_valid_nxt     = 1'b0;
    out_success_nxt   = out_success_r;
    out_count_nxt     = out_count_r;
    out_empty_res_nxt = out_empty_res_r;
    out_full_res_nxt  = out_full_res_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        state_nxt = ST_IDLE;
        if (ins_ok) begin
          count_nxt = count_r + CW'(1);
        end else if (rem_ok) begin
          count_nxt = count_r - CW'(1);
        end
        out_valid_nxt     = 1'b1;
        out_success_nxt   = ok;
        out_count_nxt     = COUNT_W'(count_nxt);  // low bits only
        out_empty_res_nxt = (count_nxt == '0);
        out_full_res_nxt  = (count_nxt == CW'(CAPACITY));
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item payload and result fields, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      key_r  <= in_value;
    end
    out_success_r   <= out_success_nxt;
    out_count_r     <= out_count_nxt;
    out_empty_res_r <= out_empty_res_nxt;
    out_full_res_r  <= out_full_res_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_success   = out_success_r;
  assign out_count     = out_count_r;
  assign out_empty_res = out_empty_res_r;
  assign out_full_res  = out_full_res_r;

`ifndef NO_ASSERTIONS
  // the update state is always left for idle in the cycle after it
  a_upd_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |=> (state_r == ST_IDLE))
    else $error("update state held longer than one cycle");

  // every accepted item gets its result strobe once the update state has registered out_valid
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 out_valid_r)
    else $error("result strobe missing after accepted item");

  // count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("member count above capacity");

  // a full store never accepts another insert
  a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins_go |-> !full)
    else $error("insert applied to a full store");
`endif

endmodule
